// ===== rtl/napl_pkg.sv =====
// Shared types and constants of the area point locator.
package napl_pkg;

	localparam int MAX_AREAS   = 1024;
	localparam int SLOT_W      = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
	localparam int CNT_W       = $clog2(MAX_AREAS + 1);
	localparam int AREA_SLOT_W = 10;
	localparam int COORD_W     = 31;
	localparam int TAG_W       = 32;
	localparam int CFG_W       = 24;
	localparam int CFG_IDX_W   = 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_JUMP_REACH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SLACK = 1'd1;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_BAND = 2'd1;
	localparam logic [1:0] KIND_JUMP = 2'd2;
	localparam logic [1:0] KIND_NEAR = 2'd3;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_POINT = 2'd2,
		OP_XY    = 2'd3
	} op_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	// Loads carry ordered bounds; queries carry the point in the low fields.
	typedef struct packed {
		op_t              op;
		logic [TAG_W-1:0] tag;
		coord_t           x_lo;
		coord_t           x_hi;
		coord_t           y_lo;
		coord_t           y_hi;
		coord_t           z_lo;
		coord_t           z_hi;
	} cmd_t;

	typedef struct packed {
		coord_t           x_lo;
		coord_t           x_hi;
		coord_t           y_lo;
		coord_t           y_hi;
		coord_t           z_lo;
		coord_t           z_hi;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic                   found;
		logic [1:0]             kind;
		logic [AREA_SLOT_W-1:0] slot;
		logic [TAG_W-1:0]       tag;
		logic [COORD_W-1:0]     gap;
		logic                   full;
	} res_t;

endpackage

// ===== rtl/napl_front.sv =====
// Front end: decodes an input item into a queued command, with ordered bounds for a load.
module napl_front import napl_pkg::*; (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [TAG_W-1:0]   entry_tag,
	input  coord_t             point_x,
	input  coord_t             point_y,
	input  coord_t             point_z,
	input  coord_t             far_x,
	input  coord_t             far_y,
	input  coord_t             far_z,
	input  coord_t             third_corner_z,
	input  coord_t             fourth_corner_z,
	output logic               push_valid,
	input  logic               push_ready,
	output cmd_t               push_data
);

	op_t    op;
	coord_t zmin_a;
	coord_t zmin_b;
	coord_t zmax_a;
	coord_t zmax_b;

	assign op         = op_t'(operation);
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		zmin_a = (point_z < far_z) ? point_z : far_z;
		zmin_b = (third_corner_z < fourth_corner_z) ? third_corner_z : fourth_corner_z;
		zmax_a = (point_z > far_z) ? point_z : far_z;
		zmax_b = (third_corner_z > fourth_corner_z) ? third_corner_z : fourth_corner_z;

		push_data.op  = op;
		push_data.tag = entry_tag;
		if (op == OP_LOAD) begin
			push_data.x_lo = (point_x < far_x) ? point_x : far_x;
			push_data.x_hi = (point_x > far_x) ? point_x : far_x;
			push_data.y_lo = (point_y < far_y) ? point_y : far_y;
			push_data.y_hi = (point_y > far_y) ? point_y : far_y;
			push_data.z_lo = (zmin_a < zmin_b) ? zmin_a : zmin_b;
			push_data.z_hi = (zmax_a > zmax_b) ? zmax_a : zmax_b;
		end else begin
			// queries keep the raw point in the low fields
			push_data.x_lo = point_x;
			push_data.x_hi = far_x;
			push_data.y_lo = point_y;
			push_data.y_hi = far_y;
			push_data.z_lo = point_z;
			push_data.z_hi = far_z;
		end
	end

endmodule

// ===== rtl/napl_queue.sv =====
// Short command queue between the front end and the table engine.
module napl_queue import napl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/napl_back.sv =====
// Table engine: area memory, scan pipeline, match selection and result register.
module napl_back import napl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [CFG_W-1:0]       jump_reach,
	input  logic [CFG_W-1:0]       height_slack,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  cmd_t                   q_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   found,
	output logic [1:0]             match_kind,
	output logic [AREA_SLOT_W-1:0] area_slot,
	output logic [TAG_W-1:0]       area_tag,
	output logic [COORD_W-1:0]     height_gap,
	output logic                   table_full
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   idx_q;
	cmd_t               cmd_q;
	logic               load_full_q;
	logic [SLOT_W-1:0]  load_slot_q;

	entry_t             mem [MAX_AREAS];

	// stage 1: memory read
	logic               v_s1_q;
	entry_t             rd_s1;
	logic [SLOT_W-1:0]  slot_s1;

	// stage 2: containment, band tests and gaps
	logic               v_s2_q;
	logic               xy_s2;
	logic               band1_s2;
	logic               band2_s2;
	logic [COORD_W-1:0] gp_s2;
	logic [COORD_W-1:0] gj_s2;
	logic [SLOT_W-1:0]  slot_s2;
	logic [TAG_W-1:0]   tag_s2;

	// best candidates per kind; kind none holds the first xy hit
	logic               have_q [4];
	logic [COORD_W-1:0] gap_q  [4];
	logic [SLOT_W-1:0]  bslot_q [4];
	logic [TAG_W-1:0]   btag_q [4];
	logic               upd    [4];

	logic               out_valid_q;
	res_t               out_q;
	res_t               res;

	logic               pop;
	logic               rd_en;
	logic               last_issue;
	logic               res_take;
	logic               pt_hit;

	logic               xy_c;
	logic               band1_c;
	logic               band2_c;
	logic [COORD_W-1:0] gp_c;
	logic [COORD_W-1:0] gj_c;

	function automatic logic signed [32:0] sx33(input coord_t v);
		sx33 = {{2{v[COORD_W-1]}}, v};
	endfunction

	assign q_ready    = (state_q == ST_IDLE);
	assign pop        = q_valid && q_ready;
	assign rd_en      = (state_q == ST_SCAN);
	assign last_issue = ((idx_q + CNT_W'(1)) == cnt_q);
	assign res_take   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// stage 2 logic on the entry just read
	always_comb begin
		logic signed [32:0] lo;
		logic signed [32:0] hi;
		logic signed [32:0] pz;
		logic signed [32:0] zj;
		logic signed [32:0] slack;
		logic signed [32:0] jump;
		logic signed [32:0] dp;
		logic signed [32:0] dj;

		lo    = sx33(rd_s1.z_lo);
		hi    = sx33(rd_s1.z_hi);
		pz    = sx33(cmd_q.z_lo);
		slack = {9'b0, height_slack};
		jump  = {9'b0, jump_reach};
		zj    = pz + jump;

		xy_c = (cmd_q.x_lo >= rd_s1.x_lo) && (cmd_q.x_lo <= rd_s1.x_hi) &&
		       (cmd_q.y_lo >= rd_s1.y_lo) && (cmd_q.y_lo <= rd_s1.y_hi);
		band1_c = (pz >= lo - slack) && (pz <= hi + slack);
		band2_c = (zj >= lo - slack) && (zj <= hi + slack);

		if (pz < lo) begin
			dp = lo - pz;
		end else if (pz > hi) begin
			dp = pz - hi;
		end else begin
			dp = '0;
		end
		if (zj < lo) begin
			dj = lo - zj;
		end else if (zj > hi) begin
			dj = zj - hi;
		end else begin
			dj = '0;
		end
		// both stay below 2^31 wherever they are used
		gp_c = dp[COORD_W-1:0];
		gj_c = dj[COORD_W-1:0];
	end

	// stage 3 candidate updates; strict compares keep the earlier slot on ties
	always_comb begin
		pt_hit = v_s2_q && xy_s2 && (cmd_q.op == OP_POINT);
		upd[KIND_NONE] = v_s2_q && xy_s2 && (cmd_q.op == OP_XY) && !have_q[KIND_NONE];
		upd[KIND_BAND] = pt_hit && band1_s2 &&
		                 (!have_q[KIND_BAND] || (gp_s2 < gap_q[KIND_BAND]));
		upd[KIND_JUMP] = pt_hit && !band1_s2 && band2_s2 &&
		                 (!have_q[KIND_JUMP] || (gj_s2 < gap_q[KIND_JUMP]));
		upd[KIND_NEAR] = pt_hit && !band1_s2 &&
		                 (!have_q[KIND_NEAR] || (gp_s2 < gap_q[KIND_NEAR]));
	end

	// result of the finished command
	always_comb begin
		res = '0;
		unique case (cmd_q.op)
			OP_LOAD: begin
				if (load_full_q) begin
					res.full = 1'b1;
				end else begin
					res.slot = AREA_SLOT_W'(load_slot_q);
					res.tag  = cmd_q.tag;
				end
			end
			OP_XY: begin
				if (have_q[KIND_NONE]) begin
					res.found = 1'b1;
					res.slot  = AREA_SLOT_W'(bslot_q[KIND_NONE]);
					res.tag   = btag_q[KIND_NONE];
				end
			end
			OP_POINT: begin
				if (have_q[KIND_BAND]) begin
					res.found = 1'b1;
					res.kind  = KIND_BAND;
					res.slot  = AREA_SLOT_W'(bslot_q[KIND_BAND]);
					res.tag   = btag_q[KIND_BAND];
					res.gap   = gap_q[KIND_BAND];
				end else if (have_q[KIND_JUMP]) begin
					res.found = 1'b1;
					res.kind  = KIND_JUMP;
					res.slot  = AREA_SLOT_W'(bslot_q[KIND_JUMP]);
					res.tag   = btag_q[KIND_JUMP];
					res.gap   = gap_q[KIND_JUMP];
				end else if (have_q[KIND_NEAR]) begin
					res.found = 1'b1;
					res.kind  = KIND_NEAR;
					res.slot  = AREA_SLOT_W'(bslot_q[KIND_NEAR]);
					res.tag   = btag_q[KIND_NEAR];
					res.gap   = gap_q[KIND_NEAR];
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				have_q[k] <= 1'b0;
			end
		end else begin
			v_s1_q <= rd_en;
			v_s2_q <= v_s1_q;
			for (int k = 0; k < 4; k++) begin
				if (upd[k]) begin
					have_q[k] <= 1'b1;
				end
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						idx_q <= '0;
						unique case (q_data.op)
							OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_DONE;
							end
							OP_LOAD: begin
								if (cnt_q != CNT_W'(MAX_AREAS)) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
								state_q <= ST_DONE;
							end
							default: begin
								for (int k = 0; k < 4; k++) begin
									have_q[k] <= 1'b0;
								end
								// an empty table has nothing to scan
								state_q <= (cnt_q == '0) ? ST_DRAIN : ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + CNT_W'(1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1_q && !v_s2_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// area memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (pop && (q_data.op == OP_LOAD) && (cnt_q != CNT_W'(MAX_AREAS))) begin
			mem[cnt_q[SLOT_W-1:0]] <= '{
				x_lo: q_data.x_lo, x_hi: q_data.x_hi,
				y_lo: q_data.y_lo, y_hi: q_data.y_hi,
				z_lo: q_data.z_lo, z_hi: q_data.z_hi,
				tag:  q_data.tag
			};
		end
		if (rd_en) begin
			rd_s1 <= mem[idx_q[SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q       <= q_data;
			load_full_q <= (cnt_q == CNT_W'(MAX_AREAS));
			load_slot_q <= cnt_q[SLOT_W-1:0];
		end
		slot_s1  <= idx_q[SLOT_W-1:0];
		xy_s2    <= xy_c;
		band1_s2 <= band1_c;
		band2_s2 <= band2_c;
		gp_s2    <= gp_c;
		gj_s2    <= gj_c;
		slot_s2  <= slot_s1;
		tag_s2   <= rd_s1.tag;
		for (int k = 0; k < 4; k++) begin
			if (upd[k]) begin
				gap_q[k]   <= (k == int'(KIND_JUMP)) ? gj_s2 : gp_s2;
				bslot_q[k] <= slot_s2;
				btag_q[k]  <= tag_s2;
			end
		end
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = out_q.found;
	assign match_kind = out_q.kind;
	assign area_slot  = out_q.slot;
	assign area_tag   = out_q.tag;
	assign height_gap = out_q.gap;
	assign table_full = out_q.full;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_AREAS))
		else $error("area count beyond table size");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q < cnt_q))
		else $error("scan index past last stored area");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1_q && !v_s2_q))
		else $error("scan pipeline busy while idle");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q |-> $past(state_q == ST_SCAN))
		else $error("memory read outside scan");

endmodule

// ===== rtl/nav_area_point_locator_top.sv =====
// Top level of the area point locator: configuration registers and block wiring.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    operation, entry_tag, point_*, far_*, corner z
//  out       output     out_valid / out_ready  found, match_kind, area_slot, area_tag,
//                                              height_gap, table_full
//  cfg       input      cfg_write              cfg_index, cfg_data
//
// A query scans the stored areas one per cycle through the area memory read port;
// the engine takes no new command until the result of the current one is registered.
// Reset empties the table and zeroes both registers; area contents are not cleared.
// A two-entry command queue lets the input side run ahead while a scan is busy,
// and the output register holds a result while the next command starts.
module nav_area_point_locator_top import napl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             operation,
	input  logic [TAG_W-1:0]       entry_tag,
	input  coord_t                 point_x,
	input  coord_t                 point_y,
	input  coord_t                 point_z,
	input  coord_t                 far_x,
	input  coord_t                 far_y,
	input  coord_t                 far_z,
	input  coord_t                 third_corner_z,
	input  coord_t                 fourth_corner_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   found,
	output logic [1:0]             match_kind,
	output logic [AREA_SLOT_W-1:0] area_slot,
	output logic [TAG_W-1:0]       area_tag,
	output logic [COORD_W-1:0]     height_gap,
	output logic                   table_full
);

	logic [CFG_W-1:0] jump_reach_q;
	logic [CFG_W-1:0] height_slack_q;
	logic             push_valid;
	logic             push_ready;
	cmd_t             push_data;
	logic             q_valid;
	logic             q_ready;
	cmd_t             q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_reach_q   <= '0;
			height_slack_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_JUMP_REACH:   jump_reach_q   <= cfg_data;
				REG_HEIGHT_SLACK: height_slack_q <= cfg_data;
				default: begin
					jump_reach_q <= jump_reach_q;
				end
			endcase
		end
	end

	napl_front u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.entry_tag       (entry_tag),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_z         (point_z),
		.far_x           (far_x),
		.far_y           (far_y),
		.far_z           (far_z),
		.third_corner_z  (third_corner_z),
		.fourth_corner_z (fourth_corner_z),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_data       (push_data)
	);

	napl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	napl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.jump_reach   (jump_reach_q),
		.height_slack (height_slack_q),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_data       (q_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_kind   (match_kind),
		.area_slot    (area_slot),
		.area_tag     (area_tag),
		.height_gap   (height_gap),
		.table_full   (table_full)
	);

endmodule
